// ===== rtl/pmi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, constants and a helper function of the particle integrator.
// ----------------------------------------------------------------------------
package pmi_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;

  localparam logic [1:0] RegGravityEnable = 2'd0;
  localparam logic [1:0] RegInwardAccel   = 2'd1;
  localparam logic [1:0] RegLocalSpace    = 2'd2;

  localparam logic signed [21:0] GravityQ16  = -22'sd642908;
  localparam logic [63:0]        NearSqLimit = 64'd42;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t             pos;
    vec3_t             vel;
    logic [15:0]       dt;
    logic signed [21:0] grav;
    logic              alive;
    logic              attract;
    logic [2:0]        neg;
    vec3_t             mag;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [34:0] x);
    logic [31:0] r;
    if (x > 35'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pmi_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_in_if
// Stream channel that carries one particle and its step parameters.
// ----------------------------------------------------------------------------
interface pmi_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic              alive;
  logic [15:0]       step_time;
  logic signed [31:0] emitter_x;
  logic signed [31:0] emitter_y;
  logic signed [31:0] emitter_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, alive, step_time,
    output emitter_x, emitter_y, emitter_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, alive, step_time,
    input  emitter_x, emitter_y, emitter_z,
    output ready
  );
endinterface

// ===== rtl/pmi_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_out_if
// Stream channel that carries one updated particle.
// ----------------------------------------------------------------------------
interface pmi_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

// ===== rtl/pmi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_front
// Five stages: velocity times step and gravity, position update, offset to
// the centre, squares, and the squared distance with the near-centre test.
// ----------------------------------------------------------------------------
module pmi_front
  import pmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  side_t             in_side,
  input  vec3_t             in_emitter,
  input  logic              gravity_enable,
  input  logic signed [31:0] inward_accel,
  input  logic              local_space,
  output logic              out_valid,
  output side_t             out_side,
  output logic [63:0]       out_sum
);

  logic              v1, v2, v3, v4, v5;
  side_t             s1, s2, s3, s4, s5;
  vec3_t             emi1, emi2;
  logic signed [48:0] prod1 [3];
  logic              sh3, sh4;
  logic [63:0]       sq4 [3];
  logic [63:0]       sum5;

  logic signed [48:0] prod_c [3];
  logic signed [38:0] gprod;
  logic signed [38:0] gshift;
  side_t             s1_c, s2_c, s3_c, s5_c;
  logic signed [48:0] step_c [3];
  logic signed [34:0] psum_c [3];
  logic [31:0]       centre_c [3];
  logic signed [32:0] d_c [3];
  logic [32:0]       mag_c [3];
  logic              sh_c;
  logic [63:0]       sum_c;

  always_comb begin
    s1_c = in_side;
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = $signed(in_side.vel[i]) * $signed({1'b0, in_side.dt});
    end
    gprod  = GravityQ16 * $signed({1'b0, in_side.dt});
    gshift = (gprod + 39'sd32768) >>> 16;
    s1_c.grav = (gravity_enable && in_side.alive) ? gshift[21:0] : '0;
  end

  always_comb begin
    s2_c = s1;
    for (int i = 0; i < 3; i++) begin
      step_c[i] = (prod1[i] + 49'sd32768) >>> 16;
      psum_c[i] = 35'($signed(s1.pos[i])) + 35'($signed(step_c[i][32:0]));
      if (s1.alive) begin
        s2_c.pos[i] = sat32(psum_c[i]);
      end
    end
  end

  always_comb begin
    s3_c = s2;
    sh_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      centre_c[i] = local_space ? 32'd0 : emi2[i];
      d_c[i] = $signed({centre_c[i][31], centre_c[i]}) - $signed({s2.pos[i][31], s2.pos[i]});
      s3_c.neg[i] = d_c[i][32];
      mag_c[i] = d_c[i][32] ? 33'(-d_c[i]) : 33'(d_c[i]);
      sh_c = sh_c | mag_c[i][32] | mag_c[i][31];
    end
    for (int i = 0; i < 3; i++) begin
      s3_c.mag[i] = sh_c ? mag_c[i][32:1] : mag_c[i][31:0];
    end
  end

  always_comb begin
    sum_c = sq4[0] + sq4[1] + sq4[2];
    s5_c = s4;
    s5_c.attract = s4.alive && (inward_accel != 32'sd0) && !(!sh4 && sum_c <= NearSqLimit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= s1_c;
      emi1 <= in_emitter;
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= prod_c[i];
      end
      s2   <= s2_c;
      emi2 <= emi1;
      s3   <= s3_c;
      sh3  <= sh_c;
      s4   <= s3;
      sh4  <= sh3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= 64'(s3.mag[i]) * 64'(s3.mag[i]);
      end
      s5   <= s5_c;
      sum5 <= sum_c;
    end
  end

  assign out_valid = v5;
  assign out_side  = s5;
  assign out_sum   = sum5;

endmodule

// ===== rtl/pmi_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pmi_sqrt
  import pmi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [63:0] in_sum,
  output logic        out_valid,
  output side_t       out_side,
  output logic [31:0] out_root
);

  logic        v    [SqrtSteps];
  side_t       sd   [SqrtSteps];
  logic [63:0] val  [SqrtSteps];
  logic [34:0] rem  [SqrtSteps];
  logic [31:0] root [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic        v_prev;
    side_t       sd_prev;
    logic [63:0] val_prev;
    logic [34:0] rem_prev;
    logic [31:0] root_prev;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign sd_prev   = in_side;
      assign val_prev  = in_sum;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign v_prev    = v[k-1];
      assign sd_prev   = sd[k-1];
      assign val_prev  = val[k-1];
      assign rem_prev  = rem[k-1];
      assign root_prev = root[k-1];
    end

    assign rem_sh = {rem_prev[32:0], val_prev[63:62]};
    assign trial  = {1'b0, root_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k]  <= sd_prev;
        val[k] <= {val_prev[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem[k]  <= rem_sh - trial;
          root[k] <= {root_prev[30:0], 1'b1};
        end else begin
          rem[k]  <= rem_sh;
          root[k] <= {root_prev[30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[SqrtSteps-1];
  assign out_side  = sd[SqrtSteps-1];
  assign out_root  = root[SqrtSteps-1];

endmodule

// ===== rtl/pmi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_div
// Three pipelined restoring dividers that form the unit vector components,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module pmi_div
  import pmi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [31:0]      in_root,
  output logic             out_valid,
  output side_t            out_side,
  output logic [2:0][30:0] out_quot
);

  logic             v   [DivSteps];
  side_t            sd  [DivSteps];
  logic [31:0]      dvs [DivSteps];
  logic [2:0][32:0] rem [DivSteps];
  logic [2:0][30:0] quo [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic             v_prev;
    side_t            sd_prev;
    logic [31:0]      dvs_prev;
    logic [2:0][32:0] rem_prev;
    logic [2:0][30:0] quo_prev;
    logic [2:0][32:0] rem_sh;

    if (k == 0) begin : g_first
      assign v_prev   = in_valid;
      assign sd_prev  = in_side;
      assign dvs_prev = in_root;
      assign quo_prev = '0;
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign rem_prev[i] = {2'b00, in_side.mag[i][31:1]};
        assign rem_sh[i]   = {rem_prev[i][31:0], in_side.mag[i][0]};
      end
    end else begin : g_rest
      assign v_prev   = v[k-1];
      assign sd_prev  = sd[k-1];
      assign dvs_prev = dvs[k-1];
      assign rem_prev = rem[k-1];
      assign quo_prev = quo[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_sh
        assign rem_sh[i] = {rem_prev[i][31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k]  <= sd_prev;
        dvs[k] <= dvs_prev;
        for (int i = 0; i < 3; i++) begin
          if (rem_sh[i] >= {1'b0, dvs_prev}) begin
            rem[k][i] <= rem_sh[i] - {1'b0, dvs_prev};
            quo[k][i] <= {quo_prev[i][29:0], 1'b1};
          end else begin
            rem[k][i] <= rem_sh[i];
            quo[k][i] <= {quo_prev[i][29:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = v[DivSteps-1];
  assign out_side  = sd[DivSteps-1];
  assign out_quot  = quo[DivSteps-1];

endmodule

// ===== rtl/pmi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_back
// Scales the unit vector by the inward acceleration and the time step, then
// sums the velocity terms and saturates.
// ----------------------------------------------------------------------------
module pmi_back
  import pmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [2:0][30:0]  in_quot,
  input  logic signed [31:0] inward_accel,
  output logic              out_valid,
  output vec3_t             out_pos,
  output vec3_t             out_vel
);

  logic              v1, v2, v3;
  side_t             s1, s2, s3;
  logic signed [63:0] acc1 [3];
  logic signed [32:0] t2   [3];
  logic signed [49:0] p3   [3];

  logic signed [31:0] u_c    [3];
  logic signed [63:0] tsh_c  [3];
  logic signed [49:0] term_c [3];
  logic signed [34:0] vsum_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i]   = in_side.neg[i] ? -$signed({1'b0, in_quot[i]}) : $signed({1'b0, in_quot[i]});
      tsh_c[i] = (acc1[i] + 64'sd536870912) >>> 30;
      term_c[i] = (p3[i] + 50'sd32768) >>> 16;
      vsum_c[i] = 35'($signed(s3.vel[i])) +
                  (s3.attract ? 35'($signed(term_c[i][33:0])) : 35'sd0);
    end
    vsum_c[1] = vsum_c[1] + 35'($signed(s3.grav));
    for (int i = 0; i < 3; i++) begin
      out_vel[i] = sat32(vsum_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= in_side;
      s2 <= s1;
      s3 <= s2;
      for (int i = 0; i < 3; i++) begin
        acc1[i] <= u_c[i] * inward_accel;
        t2[i]   <= tsh_c[i][32:0];
        p3[i]   <= t2[i] * $signed({1'b0, s2.dt});
      end
    end
  end

  assign out_valid = v3;
  assign out_pos   = s3.pos;

endmodule

// ===== rtl/particle_motion_integrate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_integrate
// Explicit Euler particle update with gravity and a point attractor.
// ----------------------------------------------------------------------------
// The block accepts one particle per clock cycle while the pipeline is not held
// and returns each updated particle in order, through the move, gravity and
// squared distance, the bit-per-stage square root, the three bit-per-stage
// dividers that form the unit vector, the acceleration products and one output
// register. The whole pipeline holds while a result waits at the output and
// the last stage is occupied.
// Configuration writes must only happen while no transaction is in flight.
module particle_motion_integrate
  import pmi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  pmi_in_if.sink               particle_in,
  pmi_out_if.source            particle_out
);

  logic              gravity_enable;
  logic signed [31:0] inward_accel;
  logic              local_space;
  logic              cfg_write;

  logic  adv;
  side_t in_side;
  vec3_t in_emitter;

  logic        f_valid;
  side_t       f_side;
  logic [63:0] f_sum;
  logic        q_valid;
  side_t       q_side;
  logic [31:0] q_root;
  logic             d_valid;
  side_t            d_side;
  logic [2:0][30:0] d_quot;
  logic  b_valid;
  vec3_t b_pos;
  vec3_t b_vel;

  logic  out_valid;
  vec3_t out_pos;
  vec3_t out_vel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_enable <= 1'b0;
      inward_accel   <= '0;
      local_space    <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        RegGravityEnable: gravity_enable <= pwdata[0];
        RegInwardAccel:   inward_accel   <= pwdata;
        RegLocalSpace:    local_space    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegGravityEnable: prdata = {31'd0, gravity_enable};
      RegInwardAccel:   prdata = inward_accel;
      RegLocalSpace:    prdata = {31'd0, local_space};
      default:          prdata = '0;
    endcase
  end

  assign adv = !b_valid || !out_valid || particle_out.ready;
  assign particle_in.ready = adv;

  always_comb begin
    in_side         = '0;
    in_side.pos     = {particle_in.pos_z, particle_in.pos_y, particle_in.pos_x};
    in_side.vel     = {particle_in.vel_z, particle_in.vel_y, particle_in.vel_x};
    in_side.dt      = particle_in.step_time;
    in_side.alive   = particle_in.alive;
    in_emitter      = {particle_in.emitter_z, particle_in.emitter_y, particle_in.emitter_x};
  end

  pmi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (particle_in.valid),
    .in_side        (in_side),
    .in_emitter     (in_emitter),
    .gravity_enable (gravity_enable),
    .inward_accel   (inward_accel),
    .local_space    (local_space),
    .out_valid      (f_valid),
    .out_side       (f_side),
    .out_sum        (f_sum)
  );

  pmi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_sum    (f_sum),
    .out_valid (q_valid),
    .out_side  (q_side),
    .out_root  (q_root)
  );

  pmi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_side   (q_side),
    .in_root   (q_root),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quot  (d_quot)
  );

  pmi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (d_valid),
    .in_side      (d_side),
    .in_quot      (d_quot),
    .inward_accel (inward_accel),
    .out_valid    (b_valid),
    .out_pos      (b_pos),
    .out_vel      (b_vel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || particle_out.ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || particle_out.ready) begin
      out_pos <= b_pos;
      out_vel <= b_vel;
    end
  end

  assign particle_out.valid     = out_valid;
  assign particle_out.new_pos_x = out_pos[0];
  assign particle_out.new_pos_y = out_pos[1];
  assign particle_out.new_pos_z = out_pos[2];
  assign particle_out.new_vel_x = out_vel[0];
  assign particle_out.new_vel_y = out_vel[1];
  assign particle_out.new_vel_z = out_vel[2];

endmodule

// ===== rtl/pmi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_checker
// Port-level assertions for the particle integrator, bound to the top level.
// ----------------------------------------------------------------------------
module pmi_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output is valid right after reset.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output transaction dropped before it was taken.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output register is empty.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("Input stalled while the output is being taken.");

endmodule

bind particle_motion_integrate pmi_checker u_pmi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (particle_in.ready),
  .out_valid (particle_out.valid),
  .out_ready (particle_out.ready)
);

// ===== verif/particle_motion_integrate_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_integrate_test
// Streams particles through the integrator under several register settings,
// with random idle gaps on both channels, and compares every updated particle
// against a fixed-point prediction of the Euler step with gravity and attractor.
// ----------------------------------------------------------------------------
module particle_motion_integrate_test;
  import pmi_pkg::*;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic        alive;
    logic [15:0] dt;
    logic [31:0] emi [3];
  } particle_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors = 0;
  int sent = 0;
  int received = 0;
  int alive_count = 0;
  int settings_count = 0;

  pmi_in_if particle_in ();
  pmi_out_if particle_out ();

  particle_motion_integrate uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .particle_in(particle_in.sink), .particle_out(particle_out.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %h expected %h", what, received, got, want);
    errors++;
  endtask

  class motion_scoreboard;
    bit          grav_on;
    logic [31:0] accel;
    bit          local_mode;
    motion_t     pending [$];

    function longint floor_shift(longint y, int n);
      return y >>> n;
    endfunction

    function longint round_shift(longint y, int n);
      return (y + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_particle(particle_t p);
      longint pos [3], vel [3], d [3], acc, dt;
      longint unsigned m [3], mx, sum, r;
      longint u, t;
      int sh;
      motion_t e;
      dt = longint'(p.dt);
      acc = longint'(signed'(accel));
      for (int i = 0; i < 3; i++) begin
        pos[i] = longint'(signed'(p.pos[i]));
        vel[i] = longint'(signed'(p.vel[i]));
      end
      if (p.alive) begin
        for (int i = 0; i < 3; i++) pos[i] = clamp32(pos[i] + round_shift(vel[i] * dt, 16));
        if (grav_on) vel[1] += round_shift(-64'sd642908 * dt, 16);
        if (acc != 0) begin
          for (int i = 0; i < 3; i++) begin
            d[i] = (local_mode ? 64'sd0 : longint'(signed'(p.emi[i]))) - pos[i];
            m[i] = d[i] < 0 ? -d[i] : d[i];
          end
          mx = m[0];
          if (m[1] > mx) mx = m[1];
          if (m[2] > mx) mx = m[2];
          sh = (mx >= (64'd1 << 31)) ? 1 : 0;
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            sum += m[i] * m[i];
          end
          if (!(sh == 0 && sum <= 64'd42)) begin
            r = root(sum);
            for (int i = 0; i < 3; i++) begin
              u = longint'((m[i] << 30) / r);
              if (d[i] < 0) u = -u;
              t = round_shift(u * acc, 30);
              vel[i] += round_shift(t * dt, 16);
            end
          end
        end
        for (int i = 0; i < 3; i++) vel[i] = clamp32(vel[i]);
      end
      for (int i = 0; i < 3; i++) begin
        e.pos[i] = pos[i][31:0];
        e.vel[i] = vel[i][31:0];
      end
      pending.push_back(e);
    endfunction

    task check_result(motion_t got);
      motion_t want;
      string axis;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result new_pos_x", got.pos[0], 32'h0);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 3; i++) begin
        axis = (i == 0) ? "x" : (i == 1) ? "y" : "z";
        if (got.pos[i] !== want.pos[i]) report_mismatch({"new_pos_", axis}, got.pos[i], want.pos[i]);
        if (got.vel[i] !== want.vel[i]) report_mismatch({"new_vel_", axis}, got.vel[i], want.vel[i]);
      end
    endtask
  endclass

  motion_scoreboard board = new();

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    particle_in.valid = 1'b0;
    particle_in.pos_x = '0; particle_in.pos_y = '0; particle_in.pos_z = '0;
    particle_in.vel_x = '0; particle_in.vel_y = '0; particle_in.vel_z = '0;
    particle_in.alive = 1'b0; particle_in.step_time = '0;
    particle_in.emitter_x = '0; particle_in.emitter_y = '0; particle_in.emitter_z = '0;
    particle_out.ready = 1'b0;
  end

  // Result side: random stalls, with stall-free stretches.
  initial begin
    motion_t got;
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      particle_out.ready <= (gap == 0);
      if (gap == 0) begin
        @(posedge clk);
        if (particle_out.valid && particle_out.ready) begin
          got.pos[0] = particle_out.new_pos_x; got.pos[1] = particle_out.new_pos_y;
          got.pos[2] = particle_out.new_pos_z; got.vel[0] = particle_out.new_vel_x;
          got.vel[1] = particle_out.new_vel_y; got.vel[2] = particle_out.new_vel_z;
          board.check_result(got);
          received++;
        end
      end else begin
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegGravityEnable: board.grav_on = value[0];
      RegInwardAccel: board.accel = value;
      RegLocalSpace: board.local_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] grav, input logic [31:0] acc,
                                input logic [31:0] loc);
    write_reg(RegGravityEnable, grav);
    write_reg(RegInwardAccel, acc);
    write_reg(RegLocalSpace, loc);
    settings_count++;
  endtask

  task automatic send_particle(input particle_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      particle_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    particle_in.valid <= 1'b1;
    particle_in.pos_x <= p.pos[0]; particle_in.pos_y <= p.pos[1];
    particle_in.pos_z <= p.pos[2];
    particle_in.vel_x <= p.vel[0]; particle_in.vel_y <= p.vel[1];
    particle_in.vel_z <= p.vel[2];
    particle_in.alive <= p.alive; particle_in.step_time <= p.dt;
    particle_in.emitter_x <= p.emi[0]; particle_in.emitter_y <= p.emi[1];
    particle_in.emitter_z <= p.emi[2];
    @(posedge clk iff particle_in.ready);
    board.note_particle(p);
    sent++;
    if (p.alive) alive_count++;
  endtask

  task automatic drain();
    particle_in.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 15) - 8;
      4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      5: return $urandom_range(0, 32'h3ffffff) - 32'h2000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pick_value();
      p.vel[i] = pick_value();
      p.emi[i] = ($urandom_range(0, 4) == 0) ? p.pos[i] + $urandom_range(0, 6) - 3
                                            : pick_value();
    end
    p.alive = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 5))
      0: p.dt = 16'hffff;
      1: p.dt = 16'h0000;
      2: p.dt = $urandom_range(0, 15);
      default: p.dt = $urandom();
    endcase
    return p;
  endfunction

  function automatic particle_t make_particle(input logic [31:0] pv, input logic [31:0] vv,
                                              input logic [31:0] ev, input logic a,
                                              input logic [15:0] dt);
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pv; p.vel[i] = vv; p.emi[i] = ev;
    end
    p.alive = a; p.dt = dt;
    return p;
  endfunction

  initial begin
    particle_t p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apply_settings(32'd1, 32'h0001_0000, 32'd0);
    send_particle(make_particle(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0, 16'hffff));
    send_particle(make_particle(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1, 16'h0000));
    send_particle(make_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'hffff));
    send_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 16'hffff));
    send_particle(make_particle(32'h0000_0010, 32'h0, 32'h0000_0012, 1'b1, 16'h8000));
    send_particle(make_particle(32'h0000_0004, 32'h0, 32'h0000_0000, 1'b1, 16'h8000));
    send_particle(make_particle(32'h0001_0000, 32'h0, 32'h0000_0000, 1'b1, 16'h0001));
    p = make_particle(32'h1234_5678, 32'hfff0_0000, 32'h0, 1'b1, 16'h1000);
    p.pos[1] = 32'h8765_4321; p.vel[2] = 32'h0010_0000;
    send_particle(p);
    drain();
    apply_settings(32'd0, 32'h7fff_ffff, 32'd1);
    send_particle(make_particle(32'h7fff_ffff, 32'h0001_0000, 32'h0, 1'b1, 16'hffff));
    send_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1, 16'hffff));
    send_particle(make_particle(32'h0000_0003, 32'h0, 32'h7fff_ffff, 1'b1, 16'hffff));
    send_particle(make_particle(32'h0000_0007, 32'h0, 32'h0, 1'b1, 16'hffff));
    drain();
    apply_settings(32'hffff_fffe, 32'h8000_0000, 32'hffff_fffe);
    send_particle(make_particle(32'h0100_0000, 32'h0, 32'hff00_0000, 1'b1, 16'hffff));
    send_particle(make_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'hffff));
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings($urandom(),
                     (phase == 1) ? 32'h0 : (phase == 2) ? 32'h7fff_ffff :
                     (phase == 3) ? 32'h8000_0000 : pick_value(), $urandom());
      for (int n = 0; n < 125; n++) send_particle(random_particle());
      drain();
    end
    $display("Covered %0d particles (%0d active) over %0d register settings.",
             sent, alive_count, settings_count);
    $display("Checked %0d updated particles with %0d mismatches.", received, errors);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout waiting for results.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pmi_pkg.sv
rtl/pmi_in_if.sv
rtl/pmi_out_if.sv
rtl/pmi_front.sv
rtl/pmi_sqrt.sv
rtl/pmi_div.sv
rtl/pmi_back.sv
rtl/particle_motion_integrate.sv
rtl/pmi_checker.sv
verif/particle_motion_integrate_test.sv
